// File: src/pawd_pkg.sv
// Shared types and constants of the peak envelope decimator.
package pawd_pkg;

    localparam int MAX_POINTS  = 512;
    localparam int POINT_W     = 9;
    localparam int FRAME_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int SCALE_W     = 16;
    localparam int VALUE_W     = 17;
    localparam int STATUS_W    = 2;
    localparam int IN_W        = 18;
    localparam int FRAC_W      = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int VALUE_MAX   = 65535;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE         = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FRAME_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHANNELS = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST   = 24'd0;
    localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = 8'd1;
    localparam logic [SCALE_W-1:0] SCALE_RST         = 16'd32767;

    typedef struct packed {
        logic               restart;
        logic [FRAME_W-1:0] frame_count;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

endpackage

// File: src/pawd_fifo.sv
// Small register queue between the front and back parts.
module pawd_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/pawd_front.sv
// Front part: configuration registers, channel selection, clamping and error checks.
module pawd_front #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_LIMIT = 32768,
    parameter int SAMPLE_W     = 17
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pawd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pawd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [pawd_pkg::IN_W-1:0]    sample,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [SAMPLE_W+2:0]                 q_data,
    output pawd_pkg::cfg_t                      cfg
);

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int EXT_W = pawd_pkg::IN_W + 1;
    localparam logic signed [EXT_W-1:0] LIMIT = EXT_W'(SAMPLE_LIMIT);

    logic [pawd_pkg::FRAME_W-1:0]  frame_count_reg, frame_count_next;
    logic [pawd_pkg::CHAN_W-1:0]   channel_count_reg, channel_count_next;
    logic [pawd_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic                          restart_reg, restart_next;
    logic [POS_W-1:0]              pos_reg, pos_next;

    logic                          accept;
    logic                          frame_zero;
    logic                          bad_channels;
    logic                          cfg_error;
    logic [pawd_pkg::STATUS_W-1:0] err_status;
    logic [pawd_pkg::CHAN_W:0]     pos_inc;
    logic signed [EXT_W-1:0]       s_ext;
    logic signed [EXT_W-1:0]       s_clamp;

    assign s_tready     = !q_full;
    assign accept       = s_tvalid && s_tready;
    assign frame_zero   = (frame_count_reg == '0);
    assign bad_channels = (channel_count_reg == '0)
                       || (channel_count_reg > pawd_pkg::CHAN_W'(MAX_CHANNELS));
    assign cfg_error    = frame_zero || bad_channels;
    assign err_status   = frame_zero ? pawd_pkg::STATUS_FRAME_ZERO
                                     : pawd_pkg::STATUS_BAD_CHANNELS;
    assign pos_inc      = (pawd_pkg::CHAN_W + 1)'(pos_reg) + 1'b1;

    always_comb
    begin
        s_ext = EXT_W'(sample);
        if (s_ext > LIMIT)
        begin
            s_clamp = LIMIT;
        end
        else if (s_ext < -LIMIT)
        begin
            s_clamp = -LIMIT;
        end
        else
        begin
            s_clamp = s_ext;
        end
    end

    assign q_push = accept && (cfg_error || (pos_reg == '0));
    assign q_data = {cfg_error, err_status, SAMPLE_W'(s_clamp)};

    assign cfg.restart     = restart_reg;
    assign cfg.frame_count = frame_count_reg;
    assign cfg.scale       = scale_reg;

    always_comb
    begin
        frame_count_next   = frame_count_reg;
        channel_count_next = channel_count_reg;
        scale_next         = scale_reg;
        restart_next       = 1'b0;
        pos_next           = pos_reg;
        if (accept && !cfg_error)
        begin
            pos_next = (pos_inc >= {1'b0, channel_count_reg}) ? '0 : POS_W'(pos_inc);
        end
        if (cfg_we)
        begin
            unique case (cfg_index)
                pawd_pkg::REG_FRAME_COUNT:
                begin
                    frame_count_next = cfg_wdata;
                    restart_next     = 1'b1;
                    pos_next         = '0;
                end
                pawd_pkg::REG_CHANNEL_COUNT:
                begin
                    channel_count_next = cfg_wdata[pawd_pkg::CHAN_W-1:0];
                    restart_next       = 1'b1;
                    pos_next           = '0;
                end
                pawd_pkg::REG_SCALE:
                begin
                    scale_next   = cfg_wdata[pawd_pkg::SCALE_W-1:0];
                    restart_next = 1'b1;
                    pos_next     = '0;
                end
                default:
                begin
                    restart_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= pawd_pkg::FRAME_COUNT_RST;
            channel_count_reg <= pawd_pkg::CHANNEL_COUNT_RST;
            scale_reg         <= pawd_pkg::SCALE_RST;
            restart_reg       <= 1'b0;
            pos_reg           <= '0;
        end
        else
        begin
            frame_count_reg   <= frame_count_next;
            channel_count_reg <= channel_count_next;
            scale_reg         <= scale_next;
            restart_reg       <= restart_next;
            pos_reg           <= pos_next;
        end
    end

endmodule

// File: src/pawd_back.sv
// Back part: peak tracking, bucket boundaries, scaling and the output register.
module pawd_back #(
    parameter int SAMPLE_W = 17,
    parameter int MAG_W    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pawd_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  logic [SAMPLE_W+2:0]                 q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [pawd_pkg::VALUE_W-1:0] value,
    output logic [pawd_pkg::POINT_W-1:0]        point_index,
    output logic                                last,
    output logic [pawd_pkg::STATUS_W-1:0]       status
);

    localparam int FW  = pawd_pkg::FRAME_W;
    localparam int PW1 = pawd_pkg::POINT_W + 1;
    localparam int PRW = SAMPLE_W + pawd_pkg::SCALE_W + 1;
    localparam logic signed [PRW-1:0] ROUND = PRW'((2 ** pawd_pkg::FRAC_W) - 1);
    localparam logic signed [PRW-1:0] VMAX  = PRW'(pawd_pkg::VALUE_MAX);

    // Capture state.
    logic [FW-1:0]                 frame_reg, frame_next;
    logic [pawd_pkg::POINT_W-1:0]  bucket_reg, bucket_next;
    logic [FW-1:0]                 end_reg, end_next;
    logic [PW1-1:0]                acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0]    best_reg, best_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;

    // Multiplier operand stage.
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_err_reg;
    logic [pawd_pkg::STATUS_W-1:0] s1_status_reg;
    logic signed [SAMPLE_W-1:0]    s1_sample_reg;
    logic [pawd_pkg::POINT_W-1:0]  s1_index_reg;
    logic                          s1_last_reg;

    // Product stage.
    logic                          s2_valid_reg, s2_valid_next;
    logic                          s2_err_reg;
    logic [pawd_pkg::STATUS_W-1:0] s2_status_reg;
    logic signed [PRW-1:0]         s2_prod_reg, s2_prod_next;
    logic [pawd_pkg::POINT_W-1:0]  s2_index_reg;
    logic                          s2_last_reg;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic signed [pawd_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [pawd_pkg::POINT_W-1:0]  index_reg;
    logic                          last_reg;
    logic [pawd_pkg::STATUS_W-1:0] status_reg;

    logic                          adv;
    logic                          pop;
    logic                          e_err;
    logic [pawd_pkg::STATUS_W-1:0] e_status;
    logic signed [SAMPLE_W-1:0]    e_sample;
    logic [MAG_W-1:0]              e_mag;
    logic                          take;
    logic signed [SAMPLE_W-1:0]    best_new;
    logic [MAG_W-1:0]              mag_new;
    logic [FW-1:0]                 frame_inc;
    logic                          hit;
    logic                          few_frames;
    logic [PW1-1:0]                pts;
    logic [FW-1:0]                 quot;
    logic [PW1-1:0]                rem;
    logic                          is_last;
    logic [PW1-1:0]                acc_sum;
    logic                          carry;
    logic signed [PRW-1:0]         adj;
    logic signed [PRW-1:0]         shifted;

    assign adv      = !out_valid_reg || m_tready;
    assign pop      = q_valid && adv;
    assign q_pop    = pop;
    assign e_err    = q_data[SAMPLE_W+2];
    assign e_status = q_data[SAMPLE_W+1:SAMPLE_W];
    assign e_sample = q_data[SAMPLE_W-1:0];

    assign e_mag    = e_sample[SAMPLE_W-1] ? MAG_W'(-e_sample) : MAG_W'(e_sample);
    assign take     = (e_mag >= mag_reg);
    assign best_new = take ? e_sample : best_reg;
    assign mag_new  = take ? e_mag : mag_reg;

    assign frame_inc  = frame_reg + 1'b1;
    assign hit        = (frame_inc >= end_reg);
    assign few_frames = (cfg.frame_count < FW'(pawd_pkg::MAX_POINTS));
    assign pts        = few_frames ? PW1'(cfg.frame_count) : PW1'(pawd_pkg::MAX_POINTS);
    assign quot       = few_frames ? FW'(1) : (cfg.frame_count >> pawd_pkg::POINT_W);
    assign rem        = few_frames ? '0 : PW1'(cfg.frame_count[pawd_pkg::POINT_W-1:0]);
    assign is_last    = ((PW1'(bucket_reg) + 1'b1) >= pts);
    assign acc_sum    = acc_reg + rem;
    assign carry      = (acc_sum >= PW1'(pawd_pkg::MAX_POINTS));

    always_comb
    begin
        frame_next  = frame_reg;
        bucket_next = bucket_reg;
        end_next    = end_reg;
        acc_next    = acc_reg;
        best_next   = best_reg;
        mag_next    = mag_reg;
        if (cfg.restart)
        begin
            frame_next  = '0;
            bucket_next = '0;
            end_next    = quot;
            acc_next    = rem;
            best_next   = '0;
            mag_next    = '0;
        end
        else if (pop && !e_err)
        begin
            if (hit)
            begin
                best_next = '0;
                mag_next  = '0;
                if (is_last)
                begin
                    frame_next  = '0;
                    bucket_next = '0;
                    end_next    = quot;
                    acc_next    = rem;
                end
                else
                begin
                    frame_next  = frame_inc;
                    bucket_next = bucket_reg + 1'b1;
                    end_next    = end_reg + quot + FW'(carry);
                    acc_next    = carry ? acc_sum - PW1'(pawd_pkg::MAX_POINTS) : acc_sum;
                end
            end
            else
            begin
                frame_next = frame_inc;
                best_next  = best_new;
                mag_next   = mag_new;
            end
        end
    end

    // The product is truncated toward zero before saturation.
    assign s2_prod_next = $signed(s1_sample_reg) * $signed({1'b0, cfg.scale});
    assign adj          = s2_prod_reg[PRW-1] ? s2_prod_reg + ROUND : s2_prod_reg;
    assign shifted      = adj >>> pawd_pkg::FRAC_W;

    always_comb
    begin
        if (s2_err_reg)
        begin
            value_next = '0;
        end
        else if (shifted > VMAX)
        begin
            value_next = pawd_pkg::VALUE_W'(VMAX);
        end
        else if (shifted < -VMAX)
        begin
            value_next = pawd_pkg::VALUE_W'(-VMAX);
        end
        else
        begin
            value_next = pawd_pkg::VALUE_W'(shifted);
        end
    end

    assign s1_valid_next  = adv ? (pop && (e_err || hit)) : s1_valid_reg;
    assign s2_valid_next  = adv ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = adv ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            bucket_reg    <= '0;
            end_reg       <= '0;
            acc_reg       <= '0;
            best_reg      <= '0;
            mag_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            bucket_reg    <= bucket_next;
            end_reg       <= end_next;
            acc_reg       <= acc_next;
            best_reg      <= best_next;
            mag_reg       <= mag_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg    <= e_err;
            s1_status_reg <= e_status;
            s1_sample_reg <= best_new;
            s1_index_reg  <= e_err ? '0 : bucket_reg;
            s1_last_reg   <= e_err || is_last;

            s2_err_reg    <= s1_err_reg;
            s2_status_reg <= s1_status_reg;
            s2_prod_reg   <= s2_prod_next;
            s2_index_reg  <= s1_index_reg;
            s2_last_reg   <= s1_last_reg;

            value_reg     <= value_next;
            index_reg     <= s2_index_reg;
            last_reg      <= s2_last_reg;
            status_reg    <= s2_err_reg ? s2_status_reg : pawd_pkg::STATUS_OK;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign value       = value_reg;
    assign point_index = index_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

// File: src/peak_abs_waveform_decimator_unit.sv
// Peak envelope decimator: a result per bucket of channel-0 samples, per input on error.
// Throughput: one input transaction per cycle while the output side keeps up.
// The result of a bucket passes, after the transaction that closes it, through the
// queue, multiplier operand stage, product stage and output register.
// Reset: asynchronous, active low; configuration returns to its defaults and the
// capture starts at frame zero. Every write to a defined register restarts the capture.
module peak_abs_waveform_decimator_unit #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_LIMIT = 32768
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pawd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pawd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // [17:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [16:0] value, [25:17] point_index
    output logic                             m_tlast,
    output logic [pawd_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

    localparam int MAG_W    = $clog2(SAMPLE_LIMIT + 1);
    localparam int SAMPLE_W = MAG_W + 1;
    localparam int ENTRY_W  = SAMPLE_W + 3;
    localparam int Q_DEPTH  = 4;

    pawd_pkg::cfg_t                      cfg;
    logic                                q_push;
    logic                                q_full;
    logic                                q_pop;
    logic                                q_valid;
    logic [ENTRY_W-1:0]                  q_in;
    logic [ENTRY_W-1:0]                  q_out;
    logic signed [pawd_pkg::VALUE_W-1:0] value;
    logic [pawd_pkg::POINT_W-1:0]        point_index;

    pawd_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_LIMIT (SAMPLE_LIMIT),
        .SAMPLE_W     (SAMPLE_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    ($signed(s_tdata[pawd_pkg::IN_W-1:0])),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in),
        .cfg       (cfg)
    );

    pawd_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    pawd_back #(
        .SAMPLE_W (SAMPLE_W),
        .MAG_W    (MAG_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .value       (value),
        .point_index (point_index),
        .last        (m_tlast),
        .status      (m_tuser)
    );

    assign m_tdata = {6'b0, point_index, value};

endmodule

// File: test/peak_abs_waveform_decimator_checker.sv
// Checker that predicts the decimator's result transactions and compares them as they leave.
module peak_abs_waveform_decimator_checker #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_LIMIT = 32768
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pawd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pawd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [23:0]                      s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [31:0]                      m_tdata,
    input  logic                             m_tlast,
    input  logic [pawd_pkg::STATUS_W-1:0]    m_tuser,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pawd_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POINT_W-1:0]        point_index;
        logic                      last;
        logic [STATUS_W-1:0]       status;
    } peak_point_t;

    peak_point_t peak_points_q[$];

    logic [FRAME_W-1:0] frames_r;
    logic [CHAN_W-1:0]  chans_r;
    logic [SCALE_W-1:0] scale_r;

    int unsigned        chan_pos;
    logic [FRAME_W-1:0] frame_idx;
    logic [POINT_W-1:0] bucket_idx;
    logic [FRAME_W-1:0] bucket_end;
    int                 best_sample;
    int                 best_mag;

    function automatic int unsigned point_total();
        return (frames_r < MAX_POINTS) ? frames_r : MAX_POINTS;
    endfunction

    function automatic logic [FRAME_W-1:0] bucket_limit(input int unsigned p);
        longint unsigned pts;
        longint unsigned q;
        pts = point_total();
        if (pts == 0)
            return '0;
        q = ((longint'(p) + 1) * longint'(frames_r)) / pts;
        return q[FRAME_W-1:0];
    endfunction

    task automatic restart_capture();
        chan_pos    = 0;
        frame_idx   = '0;
        bucket_idx  = '0;
        bucket_end  = bucket_limit(0);
        best_sample = 0;
        best_mag    = 0;
    endtask

    task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FRAME_COUNT:   frames_r = data[FRAME_W-1:0];
            REG_CHANNEL_COUNT: chans_r  = data[CHAN_W-1:0];
            REG_SCALE:         scale_r  = data[SCALE_W-1:0];
            default:           return;
        endcase
        restart_capture();
    endtask

    task automatic take_sample(input logic [IN_W-1:0] raw);
        peak_point_t want;
        int unsigned pos;
        int          smp;
        int          mag;
        longint      scaled;
        int unsigned pts;
        logic        closing;
        if (frames_r == 0 || chans_r == 0 || chans_r > MAX_CHANNELS)
        begin
            want.value       = '0;
            want.point_index = '0;
            want.last        = 1'b1;
            want.status      = (frames_r == 0) ? STATUS_FRAME_ZERO : STATUS_BAD_CHANNELS;
            peak_points_q.push_back(want);
            return;
        end
        pos = chan_pos;
        chan_pos = (pos + 1 >= chans_r) ? 0 : pos + 1;
        if (pos != 0)
            return;
        smp = $signed(raw);
        if (smp > SAMPLE_LIMIT)
            smp = SAMPLE_LIMIT;
        if (smp < -SAMPLE_LIMIT)
            smp = -SAMPLE_LIMIT;
        mag = (smp < 0) ? -smp : smp;
        if (mag >= best_mag)
        begin
            best_sample = smp;
            best_mag    = mag;
        end
        frame_idx = frame_idx + 1'b1;
        if (frame_idx < bucket_end)
            return;
        pts = point_total();
        closing = (bucket_idx + 1 >= pts);
        scaled = (longint'(best_sample) * longint'(scale_r)) / 32768;
        if (scaled > VALUE_MAX)
            scaled = VALUE_MAX;
        if (scaled < -VALUE_MAX)
            scaled = -VALUE_MAX;
        want.value       = scaled[VALUE_W-1:0];
        want.point_index = bucket_idx;
        want.last        = closing;
        want.status      = STATUS_OK;
        peak_points_q.push_back(want);
        if (closing)
        begin
            frame_idx  = '0;
            bucket_idx = '0;
        end
        else
        begin
            bucket_idx = bucket_idx + 1'b1;
        end
        bucket_end  = bucket_limit(bucket_idx);
        best_sample = 0;
        best_mag    = 0;
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_point();
        peak_point_t want;
        if (peak_points_q.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected, tdata %h last %b user %0d",
                                      m_tdata, m_tlast, m_tuser));
            return;
        end
        want = peak_points_q.pop_front();
        if (m_tdata[VALUE_W-1:0] !== want.value)
            report_mismatch($sformatf("point %0d value %0d, expected %0d", want.point_index,
                                      $signed(m_tdata[VALUE_W-1:0]), want.value));
        if (m_tdata[VALUE_W+POINT_W-1:VALUE_W] !== want.point_index)
            report_mismatch($sformatf("point index %0d, expected %0d",
                                      m_tdata[VALUE_W+POINT_W-1:VALUE_W], want.point_index));
        if (m_tdata[31:VALUE_W+POINT_W] !== '0)
            report_mismatch($sformatf("tdata padding %h is not zero", m_tdata));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("point %0d last %b, expected %b", want.point_index,
                                      m_tlast, want.last));
        if (m_tuser !== want.status)
            report_mismatch($sformatf("point %0d status %0d, expected %0d", want.point_index,
                                      m_tuser, want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_r = FRAME_COUNT_RST;
            chans_r  = CHANNEL_COUNT_RST;
            scale_r  = SCALE_RST;
            restart_capture();
            peak_points_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_point();
            if (cfg_we)
                apply_write(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                take_sample(s_tdata[IN_W-1:0]);
            pending = peak_points_q.size();
        end
    end

endmodule

// File: test/peak_abs_waveform_decimator_unit_test.sv
// Testbench top of the peak envelope decimator: stimulus, flow control and verdict.
module peak_abs_waveform_decimator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pawd_pkg::*;

    localparam int MAX_CH        = 8;
    localparam int SAMPLE_LIM    = 32768;
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 20000;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_NONE = 2'd3;

    localparam logic [IN_W-1:0] SAMPLE_MAX = 18'h1FFFF;
    localparam logic [IN_W-1:0] SAMPLE_MIN = 18'h20000;
    localparam logic [IN_W-1:0] POS_FULL   = 18'h08000;
    localparam logic [IN_W-1:0] NEG_FULL   = 18'h38000;
    localparam logic [IN_W-1:0] POS_OVER   = 18'h08001;
    localparam logic [IN_W-1:0] POS_BELOW  = 18'h07FFF;
    localparam logic [IN_W-1:0] MINUS_ONE  = 18'h3FFFF;

    typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idling_t;
    typedef enum {SHAPE_SHORT, SHAPE_LONG, SHAPE_HUGE, SHAPE_BAD} capture_shape_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [23:0]             s_tdata;
    logic                    m_tvalid;
    logic                    m_tready = 1'b1;
    logic [31:0]             m_tdata;
    logic                    m_tlast;
    logic [STATUS_W-1:0]     m_tuser;
    int                      fail_count;
    int                      pending;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    peak_abs_waveform_decimator_unit #(
        .MAX_CHANNELS(MAX_CH),
        .SAMPLE_LIMIT(SAMPLE_LIM)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    peak_abs_waveform_decimator_checker #(
        .MAX_CHANNELS(MAX_CH),
        .SAMPLE_LIMIT(SAMPLE_LIM)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SOURCE: begin src_idle_pct = 64; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 64; end
            default:     begin src_idle_pct = 7;  sink_stall_pct = 7;  end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic configure(input logic [FRAME_W-1:0] fc, input logic [CHAN_W-1:0] ch,
                             input logic [SCALE_W-1:0] sc);
        logic [CFG_DATA_W-1:0] d;
        write_reg(REG_FRAME_COUNT, fc);
        d = CFG_DATA_W'($urandom);
        d[CHAN_W-1:0] = ch;
        write_reg(REG_CHANNEL_COUNT, d);
        d = CFG_DATA_W'($urandom);
        d[SCALE_W-1:0] = sc;
        write_reg(REG_SCALE, d);
    endtask

    task automatic send_sample(input logic [IN_W-1:0] smp);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(24 - IN_W){1'b0}}, smp};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [IN_W-1:0] random_sample();
        logic [IN_W-1:0] v;
        v = IN_W'($urandom);
        case ($urandom_range(0, 7))
            0: v = SAMPLE_MAX;
            1: v = SAMPLE_MIN;
            2: v = POS_FULL;
            3: v = NEG_FULL;
            4: v = IN_W'(POS_FULL + $urandom_range(0, 2) - 1);
            5: v = IN_W'($urandom_range(0, 64) - 32);
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        int             phase;
        int             items;
        int             k;
        int             sent;
        int             waited;
        capture_shape_t shape;
        logic [FRAME_W-1:0] fc;
        logic [CHAN_W-1:0]  ch;
        logic [SCALE_W-1:0] sc;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_FRAME_COUNT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_idling(IDLE_NONE);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        settle();
        write_reg(REG_CHANNEL_COUNT, '0);
        send_sample(18'h15555);
        settle();
        write_reg(REG_FRAME_COUNT, 24'd4);
        send_sample(18'h2AAAA);
        settle();
        write_reg(REG_CHANNEL_COUNT, 24'd9);
        send_sample(MINUS_ONE);
        settle();

        // An out-of-range register write must leave the running capture alone.
        configure(24'd3, 8'd1, 16'd65535);
        send_sample(SAMPLE_MAX);
        settle();
        write_reg(CFG_INDEX_NONE, CFG_DATA_W'($urandom));
        send_sample(SAMPLE_MIN);
        send_sample(POS_OVER);
        settle();

        configure(24'd2, 8'd2, 16'd1);
        send_sample(NEG_FULL);
        send_sample(SAMPLE_MAX);
        send_sample(POS_BELOW);
        send_sample(SAMPLE_MIN);
        settle();

        configure(24'd1, 8'd8, 16'd65535);
        for (k = 0; k < 8; k++)
            send_sample(k == 0 ? MINUS_ONE : random_sample());
        settle();

        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            if (phase == 2)
                shape = SHAPE_LONG;
            else
            begin
                k = $urandom_range(0, 9);
                shape = (k == 0) ? SHAPE_BAD : (k == 1) ? SHAPE_HUGE : SHAPE_SHORT;
            end
            ch = $urandom_range(0, 4) == 0 ? 8'd8 : 8'($urandom_range(1, MAX_CH));
            case (shape)
                SHAPE_LONG:
                begin
                    fc    = FRAME_W'($urandom_range(513, 560));
                    ch    = 8'd1;
                    items = int'(fc) + int'($urandom_range(0, 20));
                end
                SHAPE_HUGE:
                begin
                    fc    = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom_range(4096, 24'hFFFFFF));
                    items = 30;
                end
                SHAPE_BAD:
                begin
                    fc = FRAME_W'($urandom_range(1, 24));
                    case ($urandom_range(0, 2))
                        0: fc = '0;
                        1: ch = '0;
                        default: ch = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(9, 255));
                    endcase
                    items = 8;
                end
                default:
                begin
                    fc    = $urandom_range(0, 7) == 0 ? 24'd1 : 24'($urandom_range(1, 24));
                    items = $urandom_range(40, 100);
                end
            endcase
            case ($urandom_range(0, 3))
                0: sc = 16'd1;
                1: sc = 16'd65535;
                default: sc = SCALE_W'($urandom_range(1, 65535));
            endcase

            configure(fc, ch, sc);
            if (phase % 3 == 0)
                write_reg(CFG_INDEX_NONE, CFG_DATA_W'($urandom));
            set_idling(idling_t'(phase % 4));
            for (k = 0; k < items; k++)
            begin
                if (k == items / 2 && (phase == 1 || $urandom_range(0, 3) == 0))
                    settle();
                send_sample(random_sample());
                sent++;
            end
            settle();
            phase++;
        end

        s_tvalid = 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
